// File: hdl/hduart_pkg.sv
// ----------------------------------------------------------------------------
// hduart_pkg
// Shared constants and types of the half-duplex 8N1 UART transceiver core.
// ----------------------------------------------------------------------------
package hduart_pkg;

   localparam int BUFFER_DEPTH = 128;
   localparam int COUNT_W      = 8;
   localparam int INDEX_W      = 7;
   localparam int TICK_W       = 16;
   localparam int POS_W        = 4;
   localparam int BYTE_W       = 8;
   localparam int DIR_W        = 2;

   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;
   localparam int REG_IDX_W    = 3;

   localparam int REQ_DATA_W   = 16;
   localparam int RSP_DATA_W   = 24;

   // direction codes
   localparam logic [DIR_W-1:0] DIR_IDLE = 2'd0;
   localparam logic [DIR_W-1:0] DIR_RX   = 2'd1;
   localparam logic [DIR_W-1:0] DIR_TX   = 2'd2;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_DIRECTION    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_BIT_TICKS    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_POLL_TICKS   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_FIRST_TICKS  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_START_TICKS  = 3'd4;

   // register reset values
   localparam logic [TICK_W-1:0] BIT_TICKS_RST   = 16'd96;
   localparam logic [TICK_W-1:0] POLL_TICKS_RST  = 16'd25;
   localparam logic [TICK_W-1:0] FIRST_TICKS_RST = 16'd80;
   localparam logic [TICK_W-1:0] START_TICKS_RST = 16'd57;

   typedef struct packed {
      logic [DIR_W-1:0]  direction;
      logic [TICK_W-1:0] bit_ticks;
      logic [TICK_W-1:0] poll_ticks;
      logic [TICK_W-1:0] first_ticks;
      logic [TICK_W-1:0] start_ticks;
      logic              arm;
      logic [DIR_W-1:0]  arm_dir;
   } cfg_type;

   typedef struct packed {
      logic              rx_level;
      logic              send_valid;
      logic [BYTE_W-1:0] send_data;
      logic              rx_rearm;
   } req_item_type;

   typedef struct packed {
      logic               tx_level;
      logic               tx_ready;
      logic               send_taken;
      logic               rx_valid;
      logic [BYTE_W-1:0]  rx_data;
      logic [INDEX_W-1:0] rx_index;
      logic               rx_full;
   } rsp_item_type;

endpackage

// File: hdl/hduart_csr.sv
// ----------------------------------------------------------------------------
// hduart_csr
// APB-style register file: direction and tick-count registers, arm pulse.
// ----------------------------------------------------------------------------
module hduart_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [hduart_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [hduart_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [hduart_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                csr_pready,
   output hduart_pkg::cfg_type                 cfg
);

   logic [hduart_pkg::DIR_W-1:0]     dir_ff;
   logic [hduart_pkg::TICK_W-1:0]    bit_ticks_ff;
   logic [hduart_pkg::TICK_W-1:0]    poll_ticks_ff;
   logic [hduart_pkg::TICK_W-1:0]    first_ticks_ff;
   logic [hduart_pkg::TICK_W-1:0]    start_ticks_ff;
   logic [hduart_pkg::REG_IDX_W-1:0] reg_idx;
   logic                             wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff         <= hduart_pkg::DIR_IDLE;
         bit_ticks_ff   <= hduart_pkg::BIT_TICKS_RST;
         poll_ticks_ff  <= hduart_pkg::POLL_TICKS_RST;
         first_ticks_ff <= hduart_pkg::FIRST_TICKS_RST;
         start_ticks_ff <= hduart_pkg::START_TICKS_RST;
      end else if (wr_en) begin
         unique case (reg_idx)
            hduart_pkg::REG_DIRECTION:   dir_ff         <= csr_pwdata[1:0];
            hduart_pkg::REG_BIT_TICKS:   bit_ticks_ff   <= csr_pwdata[15:0];
            hduart_pkg::REG_POLL_TICKS:  poll_ticks_ff  <= csr_pwdata[15:0];
            hduart_pkg::REG_FIRST_TICKS: first_ticks_ff <= csr_pwdata[15:0];
            hduart_pkg::REG_START_TICKS: start_ticks_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         hduart_pkg::REG_DIRECTION:   csr_prdata = {30'd0, dir_ff};
         hduart_pkg::REG_BIT_TICKS:   csr_prdata = {16'd0, bit_ticks_ff};
         hduart_pkg::REG_POLL_TICKS:  csr_prdata = {16'd0, poll_ticks_ff};
         hduart_pkg::REG_FIRST_TICKS: csr_prdata = {16'd0, first_ticks_ff};
         hduart_pkg::REG_START_TICKS: csr_prdata = {16'd0, start_ticks_ff};
         default:                     csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.direction   = dir_ff;
      cfg.bit_ticks   = bit_ticks_ff;
      cfg.poll_ticks  = poll_ticks_ff;
      cfg.first_ticks = first_ticks_ff;
      cfg.start_ticks = start_ticks_ff;
      // direction write restarts the engine with the new side
      cfg.arm         = wr_en && (reg_idx == hduart_pkg::REG_DIRECTION);
      cfg.arm_dir     = csr_pwdata[1:0];
   end

endmodule

// File: hdl/hduart_engine.sv
// ----------------------------------------------------------------------------
// hduart_engine
// Tick-driven UART state: shared bit timer, receive sampler, transmit shifter.
// ----------------------------------------------------------------------------
module hduart_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  hduart_pkg::cfg_type      cfg,
   input  logic                     step,
   input  hduart_pkg::req_item_type item,
   output hduart_pkg::rsp_item_type result
);

   logic [hduart_pkg::TICK_W-1:0]  cnt_ff,   cnt_in;
   logic [hduart_pkg::POS_W-1:0]   pos_ff,   pos_in;
   logic [hduart_pkg::BYTE_W-1:0]  shift_ff, shift_in;
   logic                           rx_on_ff, rx_on_in;
   logic                           done_ff,  done_in;
   logic [hduart_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                           line_ff,  line_in;

   logic                           fires;
   logic [hduart_pkg::TICK_W-1:0]  cnt_dec;
   logic [hduart_pkg::POS_W-1:0]   pos_inc;
   logic [hduart_pkg::POS_W-1:0]   pos_dec;
   logic [hduart_pkg::BYTE_W-1:0]  shift_rx;

   assign fires    = (cnt_ff <= 16'd1);
   assign cnt_dec  = cnt_ff - 16'd1;
   assign pos_inc  = pos_ff + 4'd1;
   assign pos_dec  = pos_ff - 4'd1;
   assign shift_rx = {item.rx_level, shift_ff[7:1]};

   always_comb begin
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      shift_in = shift_ff;
      rx_on_in = rx_on_ff;
      done_in  = done_ff;
      count_in = count_ff;
      line_in  = line_ff;
      result   = '0;

      if (cfg.direction == hduart_pkg::DIR_RX && rx_on_ff) begin
         if (!fires) begin
            cnt_in = cnt_dec;
         end else if (pos_ff == 4'd0) begin
            if (item.rx_level) begin
               cnt_in = cfg.poll_ticks;
            end else begin
               cnt_in   = cfg.first_ticks;
               pos_in   = 4'd1;
               shift_in = '0;
            end
         end else begin
            cnt_in = cfg.bit_ticks;
            pos_in = pos_inc;
            if (pos_inc <= 4'd9) begin
               shift_in = shift_rx;
               if (pos_inc == 4'd9) begin
                  if (count_ff < hduart_pkg::COUNT_W'(hduart_pkg::BUFFER_DEPTH)) begin
                     result.rx_valid = 1'b1;
                     result.rx_data  = shift_rx;
                     result.rx_index = count_ff[hduart_pkg::INDEX_W-1:0];
                     count_in        = count_ff + 8'd1;
                  end else begin
                     // buffer full: drop byte and stop receiving
                     result.rx_full = 1'b1;
                     rx_on_in       = 1'b0;
                     pos_in         = 4'd0;
                     cnt_in         = '0;
                  end
               end
            end else begin
               // stop period over, back to polling
               pos_in = 4'd0;
               cnt_in = cfg.poll_ticks;
            end
         end
      end else if (cfg.direction == hduart_pkg::DIR_TX) begin
         if (done_ff) begin
            if (item.send_valid) begin
               result.send_taken = 1'b1;
               shift_in = item.send_data;
               pos_in   = 4'd10;
               cnt_in   = cfg.start_ticks;
               line_in  = 1'b0;
               done_in  = 1'b0;
            end
         end else if (!fires) begin
            cnt_in = cnt_dec;
         end else begin
            cnt_in = cfg.bit_ticks;
            pos_in = pos_dec;
            if (pos_dec > 4'd1 && pos_dec <= 4'd9) begin
               line_in  = shift_ff[0];
               shift_in = {1'b0, shift_ff[7:1]};
            end else begin
               line_in = 1'b1;
               if (pos_dec == 4'd0 || pos_dec > 4'd9) begin
                  pos_in  = 4'd0;
                  done_in = 1'b1;
                  cnt_in  = '0;
               end
            end
         end
      end

      // rearm after the timer work of this tick
      if (item.rx_rearm) begin
         count_in = '0;
         if (cfg.direction == hduart_pkg::DIR_RX && !rx_on_in) begin
            rx_on_in = 1'b1;
            pos_in   = 4'd0;
            cnt_in   = cfg.poll_ticks;
         end
      end

      result.tx_level = line_in;
      result.tx_ready = (cfg.direction == hduart_pkg::DIR_TX) && done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         pos_ff   <= '0;
         shift_ff <= '0;
         rx_on_ff <= 1'b0;
         done_ff  <= 1'b1;
         count_ff <= '0;
         line_ff  <= 1'b1;
      end else if (cfg.arm) begin
         pos_ff   <= '0;
         done_ff  <= 1'b1;
         line_ff  <= 1'b1;
         rx_on_ff <= (cfg.arm_dir == hduart_pkg::DIR_RX);
         cnt_ff   <= (cfg.arm_dir == hduart_pkg::DIR_RX) ? cfg.poll_ticks : '0;
      end else if (step) begin
         cnt_ff   <= cnt_in;
         pos_ff   <= pos_in;
         shift_ff <= shift_in;
         rx_on_ff <= rx_on_in;
         done_ff  <= done_in;
         count_ff <= count_in;
         line_ff  <= line_in;
      end
   end

endmodule

// File: hdl/half_duplex_uart_transceiver_core.sv
// ----------------------------------------------------------------------------
// half_duplex_uart_transceiver_core
// Half-duplex 8N1 UART advanced by one stream word per base-clock tick.
//
//   channel  ports     word contents
//   -------  --------  -------------------------------------------------
//   in       req_*     one tick: line level, send request, rearm
//   out      rsp_*     one result per tick: tx line, status, rx byte
//   config   csr_*     direction and tick-count registers, APB style
//
// One word is taken per clock cycle while rsp_* does not stall; each result
// passes the input register, then the result register, before rsp_* shows it.
// The bit timer, receive sampler and transmit shifter advance once per word.
// Reset is synchronous; it clears the engine and register-file state and empties both stages.
// A stalled result holds in its register while one more word is taken into
// the input register; rsp_tready low then stalls req_tready.
// ----------------------------------------------------------------------------
module half_duplex_uart_transceiver_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [0] rx_level, [1] send_valid, [9:2] send_data, [10] rx_rearm, [15:11] zero
   input  logic [hduart_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] tx_level, [1] tx_ready, [2] send_taken, [3] rx_valid, [11:4] rx_data,
   // [18:12] rx_index, [19] rx_full, [23:20] zero
   output logic [hduart_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [hduart_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [hduart_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [hduart_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                              csr_pready
);

   hduart_pkg::cfg_type      cfg;
   hduart_pkg::req_item_type in_item_ff;
   hduart_pkg::req_item_type req_item;
   hduart_pkg::rsp_item_type out_item_ff;
   hduart_pkg::rsp_item_type step_result;
   logic                     in_valid_ff, in_valid_in;
   logic                     out_valid_ff, out_valid_in;
   logic                     out_free;
   logic                     advance;
   logic                     req_take;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   assign req_item.rx_level   = req_tdata[0];
   assign req_item.send_valid = req_tdata[1];
   assign req_item.send_data  = req_tdata[9:2];
   assign req_item.rx_rearm   = req_tdata[10];

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= step_result;
      end
   end

   hduart_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hduart_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (advance),
      .item   (in_item_ff),
      .result (step_result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0,
                        out_item_ff.rx_full,
                        out_item_ff.rx_index,
                        out_item_ff.rx_data,
                        out_item_ff.rx_valid,
                        out_item_ff.send_taken,
                        out_item_ff.tx_ready,
                        out_item_ff.tx_level};

endmodule

// File: hdl/hduart_checker.sv
// ----------------------------------------------------------------------------
// hduart_checker
// Port-level checks of the UART transceiver core, bound to the top level.
// ----------------------------------------------------------------------------
module hduart_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [hduart_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   // a tick either stores a byte or drops it, never both
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[3] && rsp_tdata[19]))
      else $error("rx_valid and rx_full in the same word");

   // an accepted send drives the start bit and clears ready at once
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> !rsp_tdata[0] && !rsp_tdata[1])
      else $error("send_taken without start bit or with tx_ready");

   // receiving and transmit ready exclude each other
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[3] || rsp_tdata[19]) |-> !rsp_tdata[1] && !rsp_tdata[2])
      else $error("receive event while transmit side active");

endmodule

bind half_duplex_uart_transceiver_core hduart_checker u_hduart_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the half-duplex 8N1 UART transceiver core. Every
// accepted tick word is run through a bit-exact model of the receive sampler,
// transmit shifter and bit timer. The result expected for that tick is queued
// and compared field by field with each result word the core hands out. A
// short table of directed ticks comes first. Random phases follow, with
// serial frames on the receive line, transmit traffic, buffer overflow and
// extreme tick counts. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 500000;
   localparam logic [hduart_pkg::DIR_W-1:0] DIR_UNUSED = 2'd3;

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   // [0] rx_level, [1] send_valid, [9:2] send_data, [10] rx_rearm, [15:11] zero
   logic [hduart_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   // [0] tx_level, [1] tx_ready, [2] send_taken, [3] rx_valid, [11:4] rx_data,
   // [18:12] rx_index, [19] rx_full, [23:20] zero
   logic [hduart_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                              csr_psel;
   logic                              csr_penable;
   logic                              csr_pwrite;
   logic [hduart_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [hduart_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [hduart_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                              csr_pready;

   half_duplex_uart_transceiver_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   typedef struct {
      logic                             is_reg;
      logic [hduart_pkg::REG_IDX_W-1:0] idx;
      logic [15:0]                      value;
      hduart_pkg::req_item_type         word;
      logic                             known;
      hduart_pkg::rsp_item_type         want;
   } plan_row_type;

   // shadow registers and state of the transceiver
   logic [hduart_pkg::DIR_W-1:0]   u_dir;
   logic [hduart_pkg::TICK_W-1:0]  u_bit_t;
   logic [hduart_pkg::TICK_W-1:0]  u_poll_t;
   logic [hduart_pkg::TICK_W-1:0]  u_first_t;
   logic [hduart_pkg::TICK_W-1:0]  u_start_t;
   logic [hduart_pkg::TICK_W-1:0]  u_count;
   logic [hduart_pkg::POS_W-1:0]   u_pos;
   logic [hduart_pkg::BYTE_W-1:0]  u_shift;
   logic                           u_rx_on;
   logic                           u_tx_done;
   logic [hduart_pkg::COUNT_W-1:0] u_total;
   logic                           u_line;

   hduart_pkg::rsp_item_type tick_results[$];
   plan_row_type             plan[$];
   int                       errors = 0;
   int                       words_sent = 0;
   int                       cycles = 0;
   int                       send_pct = 25;
   int                       rearm_permil = 3;
   logic                     calm = 1'b0;
   logic                     long_hold = 1'b0;

   function automatic hduart_pkg::rsp_item_type uart_tick(
      input hduart_pkg::req_item_type it);
      hduart_pkg::rsp_item_type r;
      r = '0;
      if (u_dir == hduart_pkg::DIR_RX && u_rx_on) begin
         if (u_count <= 16'd1) begin
            if (u_pos == 4'd0) begin
               if (it.rx_level) begin
                  u_count = u_poll_t;
               end else begin
                  u_count = u_first_t;
                  u_pos = 4'd1;
                  u_shift = '0;
               end
            end else begin
               u_count = u_bit_t;
               u_pos = u_pos + 1'b1;
               if (u_pos <= 4'd9) begin
                  u_shift = {it.rx_level, u_shift[7:1]};
                  if (u_pos == 4'd9) begin
                     if (u_total < hduart_pkg::BUFFER_DEPTH) begin
                        r.rx_valid = 1'b1;
                        r.rx_data = u_shift;
                        r.rx_index = u_total[hduart_pkg::INDEX_W-1:0];
                        u_total = u_total + 1'b1;
                     end else begin
                        // buffer full: drop the byte and stop listening
                        r.rx_full = 1'b1;
                        u_rx_on = 1'b0;
                        u_pos = '0;
                        u_count = '0;
                     end
                  end
               end else begin
                  u_pos = '0;
                  u_count = u_poll_t;
               end
            end
         end else begin
            u_count = u_count - 1'b1;
         end
      end else if (u_dir == hduart_pkg::DIR_TX) begin
         if (u_tx_done) begin
            if (it.send_valid) begin
               r.send_taken = 1'b1;
               u_shift = it.send_data;
               u_pos = 4'd10;
               u_count = u_start_t;
               u_line = 1'b0;
               u_tx_done = 1'b0;
            end
         end else if (u_count <= 16'd1) begin
            u_count = u_bit_t;
            u_pos = u_pos - 1'b1;
            if (u_pos > 4'd1 && u_pos <= 4'd9) begin
               u_line = u_shift[0];
               u_shift = u_shift >> 1;
            end else begin
               u_line = 1'b1;
               if (u_pos == 4'd0 || u_pos > 4'd9) begin
                  u_pos = '0;
                  u_tx_done = 1'b1;
                  u_count = '0;
               end
            end
         end else begin
            u_count = u_count - 1'b1;
         end
      end
      // rearm acts after the timer work of the tick
      if (it.rx_rearm) begin
         u_total = '0;
         if (u_dir == hduart_pkg::DIR_RX && !u_rx_on) begin
            u_rx_on = 1'b1;
            u_pos = '0;
            u_count = u_poll_t;
         end
      end
      r.tx_level = u_line;
      r.tx_ready = (u_dir == hduart_pkg::DIR_TX) && u_tx_done;
      return r;
   endfunction

   function automatic void set_reg(input logic [hduart_pkg::REG_IDX_W-1:0] idx,
                                   input logic [15:0] val);
      case (idx)
         hduart_pkg::REG_DIRECTION: begin
            // any direction write aborts a frame in flight
            u_dir = val[hduart_pkg::DIR_W-1:0];
            u_pos = '0;
            u_tx_done = 1'b1;
            u_line = 1'b1;
            u_rx_on = (u_dir == hduart_pkg::DIR_RX);
            u_count = u_rx_on ? u_poll_t : '0;
         end
         hduart_pkg::REG_BIT_TICKS:   u_bit_t = val;
         hduart_pkg::REG_POLL_TICKS:  u_poll_t = val;
         hduart_pkg::REG_FIRST_TICKS: u_first_t = val;
         hduart_pkg::REG_START_TICKS: u_start_t = val;
         default: ;
      endcase
   endfunction

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // result side: short random stalls, one long hold-off on request
   initial begin
      int stall;
      stall = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            stall = 400;
            long_hold = 1'b0;
         end else if (stall == 0 && !calm && $urandom_range(0, 99) < 3) begin
            stall = $urandom_range(1, 6);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_words
      hduart_pkg::rsp_item_type got;
      hduart_pkg::rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.tx_level   = rsp_tdata[0];
         got.tx_ready   = rsp_tdata[1];
         got.send_taken = rsp_tdata[2];
         got.rx_valid   = rsp_tdata[3];
         got.rx_data    = rsp_tdata[11:4];
         got.rx_index   = rsp_tdata[18:12];
         got.rx_full    = rsp_tdata[19];
         if (tick_results.size() == 0) begin
            $error("result word with nothing expected: %h", rsp_tdata);
            errors++;
         end else begin
            want = tick_results.pop_front();
            if (got.tx_level !== want.tx_level) begin
               $error("tx_level: expected %0d, got %0d", want.tx_level, got.tx_level);
               errors++;
            end
            if (got.tx_ready !== want.tx_ready) begin
               $error("tx_ready: expected %0d, got %0d", want.tx_ready, got.tx_ready);
               errors++;
            end
            if (got.send_taken !== want.send_taken) begin
               $error("send_taken: expected %0d, got %0d", want.send_taken, got.send_taken);
               errors++;
            end
            if (got.rx_valid !== want.rx_valid) begin
               $error("rx_valid: expected %0d, got %0d", want.rx_valid, got.rx_valid);
               errors++;
            end
            if (got.rx_data !== want.rx_data) begin
               $error("rx_data: expected %h, got %h", want.rx_data, got.rx_data);
               errors++;
            end
            if (got.rx_index !== want.rx_index) begin
               $error("rx_index: expected %0d, got %0d", want.rx_index, got.rx_index);
               errors++;
            end
            if (got.rx_full !== want.rx_full) begin
               $error("rx_full: expected %0d, got %0d", want.rx_full, got.rx_full);
               errors++;
            end
         end
      end
   end

   task automatic send_word(input hduart_pkg::req_item_type it, input logic known,
                            input hduart_pkg::rsp_item_type typed);
      hduart_pkg::rsp_item_type due;
      if (!calm && $urandom_range(0, 99) < 4) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, it.rx_rearm, it.send_data, it.send_valid, it.rx_level};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      due = uart_tick(it);
      tick_results.push_back(known ? typed : due);
      words_sent++;
   endtask

   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (tick_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [hduart_pkg::REG_IDX_W-1:0] idx,
                            input logic [15:0] val);
      logic [15:0] upper;
      upper = $urandom_range(0, 65535);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {upper, val};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      set_reg(idx, val);
   endtask

   // count ticks with the line held at level, or random when wild
   task automatic feed(input logic level, input logic wild, input int count);
      hduart_pkg::req_item_type it;
      repeat (count) begin
         it.rx_level = wild ? 1'($urandom_range(0, 1)) : level;
         it.send_valid = ($urandom_range(0, 99) < send_pct);
         it.send_data = 8'($urandom_range(0, 255));
         it.rx_rearm = ($urandom_range(0, 999) < rearm_permil);
         send_word(it, 1'b0, '0);
      end
   endtask

   task automatic send_frame(input logic [7:0] b);
      int bt;
      bt = (u_bit_t == 0) ? 1 : int'(u_bit_t);
      feed(1'b0, 1'b0, bt);
      for (int i = 0; i < 8; i++) feed(b[i], 1'b0, bt);
      feed(1'b1, 1'b0, bt + $urandom_range(0, 4));
   endtask

   task automatic rx_traffic(input int count);
      int stop_at;
      int pick;
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 85) begin
            send_frame(8'($urandom_range(0, 255)));
         end else if (pick < 93) begin
            // glitch low for one tick
            feed(1'b0, 1'b0, 1);
            feed(1'b1, 1'b0, $urandom_range(1, 8));
         end else begin
            // line stuck low, then released mid-frame
            feed(1'b0, 1'b0, $urandom_range(2, 30));
            feed(1'b1, 1'b0, $urandom_range(1, 30));
         end
      end
   endtask

   task automatic plan_reg(input logic [hduart_pkg::REG_IDX_W-1:0] idx,
                           input logic [15:0] val);
      plan_row_type row;
      row = '{default: '0};
      row.is_reg = 1'b1;
      row.idx = idx;
      row.value = val;
      plan.push_back(row);
   endtask

   task automatic plan_word(input logic rx, input logic send, input logic [7:0] data,
                            input logic rearm, input logic known, input logic e_tx,
                            input logic e_ready, input logic e_taken);
      plan_row_type row;
      row = '{default: '0};
      row.word.rx_level = rx;
      row.word.send_valid = send;
      row.word.send_data = data;
      row.word.rx_rearm = rearm;
      row.known = known;
      row.want.tx_level = e_tx;
      row.want.tx_ready = e_ready;
      row.want.send_taken = e_taken;
      plan.push_back(row);
   endtask

   initial begin
      int bt;
      logic [hduart_pkg::DIR_W-1:0] mode;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;

      u_dir = hduart_pkg::DIR_IDLE;
      u_bit_t = hduart_pkg::BIT_TICKS_RST;
      u_poll_t = hduart_pkg::POLL_TICKS_RST;
      u_first_t = hduart_pkg::FIRST_TICKS_RST;
      u_start_t = hduart_pkg::START_TICKS_RST;
      u_count = '0;
      u_pos = '0;
      u_shift = '0;
      u_rx_on = 1'b0;
      u_tx_done = 1'b1;
      u_total = '0;
      u_line = 1'b1;

      // idle after reset: sends and rearm are ignored
      plan_word(1'b0, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
      plan_word(1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
      plan_reg(hduart_pkg::REG_START_TICKS, 16'd1);
      plan_reg(hduart_pkg::REG_BIT_TICKS, 16'd1);
      plan_reg(hduart_pkg::REG_DIRECTION, 16'(hduart_pkg::DIR_TX));
      plan_word(1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
      // start bit shows in the tick the byte is taken
      plan_word(1'b0, 1'b1, 8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
      // busy: this send is dropped
      plan_word(1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      repeat (10) plan_word(1'b0, 1'b0, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      plan_word(1'b0, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      plan_reg(hduart_pkg::REG_DIRECTION, 16'(DIR_UNUSED));
      plan_word(1'b0, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
      plan_reg(hduart_pkg::REG_DIRECTION, 16'(hduart_pkg::DIR_RX));
      plan_word(1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      plan_word(1'b1, 1'b1, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      plan_word(1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_reg) begin
            drain_block();
            write_reg(plan[i].idx, plan[i].value);
         end else begin
            send_word(plan[i].word, plan[i].known, plan[i].want);
         end
      end

      // mixed random phases
      for (int ph = 0; ph < 8; ph++) begin
         drain_block();
         bt = $urandom_range(1, 6);
         write_reg(hduart_pkg::REG_BIT_TICKS, 16'(bt));
         write_reg(hduart_pkg::REG_POLL_TICKS, 16'($urandom_range(1, bt)));
         write_reg(hduart_pkg::REG_FIRST_TICKS, 16'(bt + bt / 2 + $urandom_range(0, 1)));
         write_reg(hduart_pkg::REG_START_TICKS, 16'($urandom_range(1, bt + 2)));
         mode = (ph % 2 == 0) ? hduart_pkg::DIR_RX : hduart_pkg::DIR_TX;
         if (ph == 6) mode = 2'($urandom_range(0, 3));
         write_reg(hduart_pkg::REG_DIRECTION, 16'(mode));
         calm = (ph == 2);
         if (ph == 0) long_hold = 1'b1;
         if (mode == hduart_pkg::DIR_RX) begin
            rx_traffic(90);
         end else if (ph == 1) begin
            feed(1'b0, 1'b1, 45);
            drain_block();
            feed(1'b0, 1'b1, 45);
         end else begin
            feed(1'b0, 1'b1, 90);
         end
      end
      calm = 1'b0;

      // overflow the receive buffer, then rearm
      drain_block();
      write_reg(hduart_pkg::REG_BIT_TICKS, 16'd1);
      write_reg(hduart_pkg::REG_POLL_TICKS, 16'd1);
      write_reg(hduart_pkg::REG_FIRST_TICKS, 16'd1);
      write_reg(hduart_pkg::REG_DIRECTION, 16'(hduart_pkg::DIR_RX));
      rearm_permil = 0;
      while (u_rx_on) send_frame(8'($urandom_range(0, 255)));
      repeat (3) send_frame(8'($urandom_range(0, 255)));
      rearm_permil = 1000;
      feed(1'b1, 1'b0, 1);
      rearm_permil = 0;
      repeat (4) send_frame(8'($urandom_range(0, 255)));
      rearm_permil = 3;

      // longest bit period: the frame is cut short by the next direction write
      drain_block();
      write_reg(hduart_pkg::REG_BIT_TICKS, 16'hFFFF);
      write_reg(hduart_pkg::REG_START_TICKS, 16'd1);
      write_reg(hduart_pkg::REG_DIRECTION, 16'(hduart_pkg::DIR_TX));
      feed(1'b0, 1'b1, 60);

      drain_block();
      write_reg(hduart_pkg::REG_POLL_TICKS, 16'hFFFF);
      write_reg(hduart_pkg::REG_FIRST_TICKS, 16'hFFFF);
      write_reg(hduart_pkg::REG_START_TICKS, 16'hFFFF);
      write_reg(hduart_pkg::REG_DIRECTION, 16'(hduart_pkg::DIR_RX));
      feed(1'b0, 1'b1, 40);

      // zero tick counts behave like one
      drain_block();
      write_reg(hduart_pkg::REG_BIT_TICKS, 16'd0);
      write_reg(hduart_pkg::REG_POLL_TICKS, 16'd0);
      write_reg(hduart_pkg::REG_FIRST_TICKS, 16'd0);
      write_reg(hduart_pkg::REG_START_TICKS, 16'd0);
      write_reg(hduart_pkg::REG_DIRECTION, 16'(hduart_pkg::DIR_RX));
      repeat (6) send_frame(8'($urandom_range(0, 255)));

      drain_block();
      write_reg(hduart_pkg::REG_DIRECTION, 16'(hduart_pkg::DIR_TX));
      feed(1'b0, 1'b1, 60);

      drain_block();
      rearm_permil = 200;
      write_reg(hduart_pkg::REG_DIRECTION, 16'(DIR_UNUSED));
      feed(1'b0, 1'b1, 30);
      drain_block();
      write_reg(hduart_pkg::REG_DIRECTION, 16'(hduart_pkg::DIR_IDLE));
      feed(1'b0, 1'b1, 20);

      drain_block();
      if (errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
